[src/otn_pkg.sv]
// shared types and constants for the oriented triangle normal unit
`default_nettype none
package otn_pkg;
  localparam logic [1:0] FUNC_POINT = 2'd0;
  localparam logic [1:0] FUNC_TETRA = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;
  localparam int CoordW = 20;
  localparam int VertW = 10;
  localparam int NormW = 43;

  typedef struct packed {
    logic start_load;
    logic start_query;
    logic scan_step;
    logic fetch;
    logic arith_step;
    logic [2:0] arith_phase;
  } otn_cmd_t;

  typedef struct packed {
    logic scan_done;
  } otn_stat_t;
endpackage
`default_nettype wire

[src/otn_ctrl.sv]
// controller state machine for the oriented triangle normal unit
`default_nettype none
module otn_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic [1:0] func,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire otn_pkg::otn_stat_t stat,
  output otn_pkg::otn_cmd_t cmd
);
  import otn_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_ARITH = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;
  localparam logic [2:0] LastPhase = 3'd6;

  logic [2:0] state, state_next;
  logic [2:0] phase, phase_next;
  logic [1:0] fcnt, fcnt_next;
  logic acc;

  assign acc = in_valid && in_ready;
  assign in_ready = (state == S_IDLE) || (state == S_OUT && out_ready);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    phase_next = phase;
    fcnt_next = fcnt;
    cmd = '0;
    cmd.arith_phase = phase;
    case (state)
      S_IDLE, S_OUT: begin
        if (state == S_OUT && out_ready) state_next = S_IDLE;
        if (acc) begin
          if (func == FUNC_QUERY) begin
            cmd.start_query = 1'b1;
            state_next = S_SCAN;
          end else begin
            cmd.start_load = 1'b1;
            state_next = S_OUT;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_next = S_FETCH;
          fcnt_next = 2'd0;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        fcnt_next = fcnt + 2'd1;
        if (fcnt == 2'd3) begin
          state_next = S_ARITH;
          phase_next = 3'd0;
        end
      end
      S_ARITH: begin
        cmd.arith_step = 1'b1;
        phase_next = phase + 3'd1;
        if (phase == LastPhase) state_next = S_OUT;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 3'd0;
      fcnt <= 2'd0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      fcnt <= fcnt_next;
    end
  end
endmodule
`default_nettype wire

[src/otn_datapath.sv]
// tables, tetrahedron scan and normal arithmetic
`default_nettype none
module otn_datapath #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_TETRA = 1024
) (
  input  wire logic clk,
  input  wire otn_pkg::otn_cmd_t cmd,
  output otn_pkg::otn_stat_t stat,
  input  wire logic [1:0] func,
  input  wire logic [9:0] slot,
  input  wire logic signed [19:0] coord_x,
  input  wire logic signed [19:0] coord_y,
  input  wire logic signed [19:0] coord_z,
  input  wire logic [9:0] vert_a,
  input  wire logic [9:0] vert_b,
  input  wire logic [9:0] vert_c,
  input  wire logic [9:0] vert_d,
  input  wire logic batch_end,
  input  wire logic [10:0] tetra_count,
  output logic signed [42:0] normal_x,
  output logic signed [42:0] normal_y,
  output logic signed [42:0] normal_z,
  output logic signed [19:0] centre_x,
  output logic signed [19:0] centre_y,
  output logic signed [19:0] centre_z,
  output logic faces_out,
  output logic found,
  output logic batch_end_out
);
  import otn_pkg::*;
  localparam int PAW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int TAW = (MAX_TETRA > 1) ? $clog2(MAX_TETRA) : 1;
  localparam int CntW = TAW + 1;
  localparam logic [23:0] Recip3 = 24'd5592406;

  logic [3*CoordW-1:0] pmem [MAX_POINTS];
  logic [4*VertW-1:0] tmem [MAX_TETRA];

  logic [9:0] va, vb, vc;
  logic [CntW-1:0] idx, lim;
  logic [4*VertW-1:0] trd;
  logic trd_ok, hit;
  logic [VertW-1:0] fourth;
  logic [3*CoordW-1:0] prd;
  logic prd_ok;
  logic signed [CoordW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz;
  logic signed [CoordW:0] ux, uy, uz, wx, wy, wz;
  logic signed [CoordW+1:0] sx, sy, sz;
  logic signed [2*CoordW+1:0] m0, m1;
  logic signed [NormW-1:0] nx, ny, nz;
  logic signed [CoordW:0] dx, dy, dz;
  logic signed [63:0] prod, dot;
  logic signed [CoordW-1:0] gdiv;
  logic signed [CoordW+1:0] sneg;
  logic [CoordW:0] gmag;
  logic [44:0] gprod;
  logic [CoordW-1:0] gq;
  logic [10:0] cnt_sat;

  // point and tetra tables
  always_ff @(posedge clk) begin
    if (cmd.start_load && func == FUNC_POINT && {22'd0, slot} < MAX_POINTS)
      pmem[PAW'(slot)] <= {coord_x, coord_y, coord_z};
    if (cmd.start_load && func == FUNC_TETRA && {22'd0, slot} < MAX_TETRA)
      tmem[TAW'(slot)] <= {vert_a, vert_b, vert_c, vert_d};
  end

  assign cnt_sat = ({21'd0, tetra_count} > MAX_TETRA) ? 11'(MAX_TETRA) : tetra_count;
  always_comb begin
    hit = 1'b0;
    fourth = trd[VertW-1:0];
    if (trd[39:30] == va && trd[29:20] == vb && trd[19:10] == vc) begin
      hit = 1'b1; fourth = trd[9:0];
    end else if (trd[39:30] == va && trd[29:20] == vb && trd[9:0] == vc) begin
      hit = 1'b1; fourth = trd[19:10];
    end else if (trd[39:30] == va && trd[19:10] == vb && trd[9:0] == vc) begin
      hit = 1'b1; fourth = trd[29:20];
    end else if (trd[29:20] == va && trd[19:10] == vb && trd[9:0] == vc) begin
      hit = 1'b1; fourth = trd[39:30];
    end
  end
  assign stat.scan_done = (trd_ok && hit) || (idx >= lim && !trd_ok);

  // scan: one table read per cycle, compare on the registered word
  logic [9:0] fourth_r;
  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      va <= vert_a; vb <= vert_b; vc <= vert_c;
      batch_end_out <= batch_end;
      idx <= '0;
      lim <= CntW'(cnt_sat);
      trd_ok <= 1'b0;
      found <= 1'b0;
    end else if (cmd.start_load) begin
      found <= 1'b0;
      batch_end_out <= 1'b0;
    end else if (cmd.scan_step) begin
      if (trd_ok && hit) begin
        found <= 1'b1;
        fourth_r <= fourth;
        trd_ok <= 1'b0;
      end else if (idx < lim) begin
        trd <= tmem[idx[TAW-1:0]];
        trd_ok <= 1'b1;
        idx <= idx + 1'b1;
      end else begin
        trd_ok <= 1'b0;
      end
    end
  end

  // point fetch: a, b, c, fourth
  logic [9:0] faddr;
  logic [1:0] fcount;
  always_comb begin
    case (fcount)
      2'd0: faddr = va;
      2'd1: faddr = vb;
      2'd2: faddr = vc;
      default: faddr = fourth_r;
    endcase
  end
  always_ff @(posedge clk) begin
    if (cmd.start_query) fcount <= 2'd0;
    else if (cmd.fetch) fcount <= fcount + 2'd1;
    if (cmd.fetch) begin
      prd <= pmem[PAW'(faddr)];
      prd_ok <= {22'd0, faddr} < MAX_POINTS;
    end
  end
  // capture in the cycle after each read
  logic cap;
  logic [1:0] cap_sel;
  always_ff @(posedge clk) begin
    cap <= cmd.fetch;
    cap_sel <= fcount;
  end
  logic signed [CoordW-1:0] rx, ry, rz;
  assign rx = prd_ok ? prd[59:40] : '0;
  assign ry = prd_ok ? prd[39:20] : '0;
  assign rz = prd_ok ? prd[19:0] : '0;
  always_ff @(posedge clk) begin
    if (cap) begin
      case (cap_sel)
        2'd0: begin ax <= rx; ay <= ry; az <= rz; end
        2'd1: begin bx <= rx; by <= ry; bz <= rz; end
        2'd2: begin cx <= rx; cy <= ry; cz <= rz; end
        default: begin px <= rx; py <= ry; pz <= rz; end
      endcase
    end
  end

  // arithmetic sequence: phase 0 at the first arith cycle (fourth point lands then)
  always_comb begin
    ux = (CoordW+1)'(bx) - (CoordW+1)'(ax);
    uy = (CoordW+1)'(by) - (CoordW+1)'(ay);
    uz = (CoordW+1)'(bz) - (CoordW+1)'(az);
    wx = (CoordW+1)'(cx) - (CoordW+1)'(ax);
    wy = (CoordW+1)'(cy) - (CoordW+1)'(ay);
    wz = (CoordW+1)'(cz) - (CoordW+1)'(az);
    sx = (CoordW+2)'(ax) + (CoordW+2)'(bx) + (CoordW+2)'(cx);
    sy = (CoordW+2)'(ay) + (CoordW+2)'(by) + (CoordW+2)'(cy);
    sz = (CoordW+2)'(az) + (CoordW+2)'(bz) + (CoordW+2)'(cz);
  end
  always_comb begin
    m0 = '0; m1 = '0;
    case (cmd.arith_phase)
      3'd1: begin m0 = uy * wz; m1 = uz * wy; end
      3'd2: begin m0 = uz * wx; m1 = ux * wz; end
      3'd3: begin m0 = ux * wy; m1 = uy * wx; end
      default: begin m0 = '0; m1 = '0; end
    endcase
  end
  // divide by three on the magnitude, truncating toward zero
  logic signed [CoordW+1:0] ssel;
  always_comb begin
    case (cmd.arith_phase)
      3'd1: ssel = sx;
      3'd2: ssel = sy;
      default: ssel = sz;
    endcase
    sneg = -ssel;
    gmag = ssel[CoordW+1] ? sneg[CoordW:0] : ssel[CoordW:0];
    gprod = gmag * Recip3;
    gq = gprod[43:24];
    gdiv = ssel[CoordW+1] ? -gq : gq;
  end
  always_comb begin
    dx = (CoordW+1)'(centre_x) - (CoordW+1)'(px);
    dy = (CoordW+1)'(centre_y) - (CoordW+1)'(py);
    dz = (CoordW+1)'(centre_z) - (CoordW+1)'(pz);
    case (cmd.arith_phase)
      3'd4: prod = 64'(nx) * 64'(dx);
      3'd5: prod = 64'(ny) * 64'(dy);
      default: prod = 64'(nz) * 64'(dz);
    endcase
  end
  logic signed [NormW-1:0] nd;
  assign nd = NormW'(m0 - m1);
  always_ff @(posedge clk) begin
    if (cmd.start_load) begin
      normal_x <= '0; normal_y <= '0; normal_z <= '0;
      centre_x <= '0; centre_y <= '0; centre_z <= '0;
      faces_out <= 1'b0;
    end
    if (cmd.arith_step) begin
      case (cmd.arith_phase)
        3'd1: begin nx <= nd; centre_x <= gdiv; dot <= '0; end
        3'd2: begin ny <= nd; centre_y <= gdiv; end
        3'd3: begin nz <= nd; centre_z <= gdiv; end
        3'd4, 3'd5: dot <= dot + prod;
        3'd6: begin
          faces_out <= found && (dot + prod > 0);
          if (found && !(dot + prod > 0)) begin
            normal_x <= -nx; normal_y <= -ny; normal_z <= -nz;
          end else begin
            normal_x <= nx; normal_y <= ny; normal_z <= nz;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

[src/oriented_triangle_normal_unit.sv]
// Oriented triangle normal unit: point and tetrahedron tables with face queries.
// Input channel (in_valid/in_ready) takes one item per transfer: func selects a
// point write, a tetrahedron write or a triangle query; func 3 writes nothing.
// Output channel (out_valid/out_ready) returns one result per item; loads (and
// func 3) return all zeros. A load's result is valid in the cycle after its
// transfer. A query scans tetrahedra 0..tetra_count-1 one per cycle through a
// single table read port, stopping at the first match, then fetches four points
// and runs the cross product on a shared multiplier pair alongside the centroid,
// then the dot product that orients the normal. A new item is taken in the cycle
// its predecessor's result transfers. tetra_count is written over the APB port;
// the scan limit saturates at MAX_TETRA.
// Reset clears the controller and tetra_count; the tables are not cleared and
// must be written before being queried. While out_ready is low the result holds.
`default_nettype none
module oriented_triangle_normal_unit #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_TETRA = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [1:0] func,
  input  wire logic [9:0] slot,
  input  wire logic signed [19:0] coord_x,
  input  wire logic signed [19:0] coord_y,
  input  wire logic signed [19:0] coord_z,
  input  wire logic [9:0] vert_a,
  input  wire logic [9:0] vert_b,
  input  wire logic [9:0] vert_c,
  input  wire logic [9:0] vert_d,
  input  wire logic batch_end,
  output logic out_valid,
  input  wire logic out_ready,
  output logic signed [42:0] normal_x,
  output logic signed [42:0] normal_y,
  output logic signed [42:0] normal_z,
  output logic signed [19:0] centre_x,
  output logic signed [19:0] centre_y,
  output logic signed [19:0] centre_z,
  output logic faces_out,
  output logic found,
  output logic batch_end_out
);
  import otn_pkg::*;
  localparam logic [1:0] REG_TETRA_COUNT = 2'd0;
  logic [10:0] tetra_count;
  otn_cmd_t cmd;
  otn_stat_t stat;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) tetra_count <= '0;
    else if (psel && penable && pwrite && paddr == REG_TETRA_COUNT)
      tetra_count <= pwdata[10:0];
  end
  assign prdata = (paddr == REG_TETRA_COUNT) ? {21'd0, tetra_count} : 32'd0;

  otn_ctrl u_ctrl (
    .clk, .rst, .in_valid, .func, .in_ready, .out_valid, .out_ready,
    .stat, .cmd
  );

  otn_datapath #(.MAX_POINTS(MAX_POINTS), .MAX_TETRA(MAX_TETRA)) u_dp (
    .clk, .cmd, .stat, .func, .slot, .coord_x, .coord_y, .coord_z,
    .vert_a, .vert_b, .vert_c, .vert_d, .batch_end, .tetra_count,
    .normal_x, .normal_y, .normal_z, .centre_x, .centre_y, .centre_z,
    .faces_out, .found, .batch_end_out
  );
endmodule
`default_nettype wire

[src/otn_checker.sv]
// port-level checks for the oriented triangle normal unit
`default_nettype none
module otn_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic found,
  input wire logic faces_out,
  input wire logic pready
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_face_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && faces_out |-> found) else $error("faces_out without match");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready) else $error("input taken while stalled");
  a_pready: assert property (@(posedge clk) pready) else $error("pready low");
endmodule
bind oriented_triangle_normal_unit otn_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
  .found, .faces_out, .pready
);
`default_nettype wire

[sim/tb.sv]
// testbench for the oriented triangle normal unit with a self-checking scoreboard
module tb;
  import otn_pkg::*;

  typedef struct {
    logic [1:0] func;
    logic [9:0] slot;
    logic signed [19:0] cx, cy, cz;
    logic [9:0] va, vb, vc, vd;
    logic be;
  } load_item_t;

  typedef struct {
    logic signed [42:0] nx, ny, nz;
    logic signed [19:0] gx, gy, gz;
    logic fo, fd, be;
  } face_t;

  class face_scoreboard;
    int pts[1024][3];
    logic [9:0] tets[1024][4];
    bit pt_ok[1024];
    bit tet_ok[1024];
    int tet_count;
    face_t face_q[$];
    int errors, n_query, n_found, n_flip;

    function int skip_pos(int j, logic [9:0] a, logic [9:0] b, logic [9:0] c);
      if (tets[j][0] == a && tets[j][1] == b && tets[j][2] == c) return 3;
      if (tets[j][0] == a && tets[j][1] == b && tets[j][3] == c) return 2;
      if (tets[j][0] == a && tets[j][2] == b && tets[j][3] == c) return 1;
      if (tets[j][1] == a && tets[j][2] == b && tets[j][3] == c) return 0;
      return -1;
    endfunction

    function int scan_limit();
      return tet_count > 1024 ? 1024 : tet_count;
    endfunction

    // true when the query touches only written table entries
    function bit query_ok(logic [9:0] a, logic [9:0] b, logic [9:0] c);
      int p;
      if (!pt_ok[a] || !pt_ok[b] || !pt_ok[c]) return 0;
      for (int j = 0; j < scan_limit(); j++) begin
        if (!tet_ok[j]) return 0;
        p = skip_pos(j, a, b, c);
        if (p >= 0) return pt_ok[tets[j][p]];
      end
      return 1;
    endfunction

    function void note_transfer(load_item_t it);
      face_t r;
      longint a[3], b[3], c[3], p[3], u[3], v[3], n[3], g[3], dot;
      int pos;
      logic [9:0] fourth;
      r = '{default: '0};
      if (it.func == FUNC_POINT) begin
        pts[it.slot][0] = it.cx;
        pts[it.slot][1] = it.cy;
        pts[it.slot][2] = it.cz;
        pt_ok[it.slot] = 1;
      end else if (it.func == FUNC_TETRA) begin
        tets[it.slot][0] = it.va;
        tets[it.slot][1] = it.vb;
        tets[it.slot][2] = it.vc;
        tets[it.slot][3] = it.vd;
        tet_ok[it.slot] = 1;
      end else if (it.func == FUNC_QUERY) begin
        n_query++;
        pos = -1;
        fourth = '0;
        for (int j = 0; j < scan_limit(); j++) begin
          pos = skip_pos(j, it.va, it.vb, it.vc);
          if (pos >= 0) begin
            fourth = tets[j][pos];
            break;
          end
        end
        for (int k = 0; k < 3; k++) begin
          a[k] = pts[it.va][k];
          b[k] = pts[it.vb][k];
          c[k] = pts[it.vc][k];
          u[k] = b[k] - a[k];
          v[k] = c[k] - a[k];
          g[k] = (a[k] + b[k] + c[k]) / 3;
        end
        n[0] = u[1] * v[2] - u[2] * v[1];
        n[1] = u[2] * v[0] - u[0] * v[2];
        n[2] = u[0] * v[1] - u[1] * v[0];
        if (pos >= 0) begin
          n_found++;
          r.fd = 1;
          for (int k = 0; k < 3; k++) p[k] = pts[fourth][k];
          dot = n[0] * (g[0] - p[0]) + n[1] * (g[1] - p[1]) + n[2] * (g[2] - p[2]);
          r.fo = dot > 0;
          if (!r.fo) begin
            n_flip++;
            for (int k = 0; k < 3; k++) n[k] = -n[k];
          end
        end
        r.nx = n[0][42:0];
        r.ny = n[1][42:0];
        r.nz = n[2][42:0];
        r.gx = g[0][19:0];
        r.gy = g[1][19:0];
        r.gz = g[2][19:0];
        r.be = it.be;
      end
      face_q.push_back(r);
    endfunction

    function void check_result(face_t got);
      face_t e;
      if (face_q.size() == 0) begin
        $display("%0t: result with nothing expected", $time);
        errors++;
        return;
      end
      e = face_q.pop_front();
      if (got.nx !== e.nx) begin
        $display("%0t: normal_x exp %0d got %0d", $time, e.nx, got.nx); errors++;
      end
      if (got.ny !== e.ny) begin
        $display("%0t: normal_y exp %0d got %0d", $time, e.ny, got.ny); errors++;
      end
      if (got.nz !== e.nz) begin
        $display("%0t: normal_z exp %0d got %0d", $time, e.nz, got.nz); errors++;
      end
      if (got.gx !== e.gx) begin
        $display("%0t: centre_x exp %0d got %0d", $time, e.gx, got.gx); errors++;
      end
      if (got.gy !== e.gy) begin
        $display("%0t: centre_y exp %0d got %0d", $time, e.gy, got.gy); errors++;
      end
      if (got.gz !== e.gz) begin
        $display("%0t: centre_z exp %0d got %0d", $time, e.gz, got.gz); errors++;
      end
      if (got.fo !== e.fo) begin
        $display("%0t: faces_out exp %0d got %0d", $time, e.fo, got.fo); errors++;
      end
      if (got.fd !== e.fd) begin
        $display("%0t: found exp %0d got %0d", $time, e.fd, got.fd); errors++;
      end
      if (got.be !== e.be) begin
        $display("%0t: batch_end_out exp %0d got %0d", $time, e.be, got.be); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] func = '0;
  logic [9:0] slot = '0;
  logic signed [19:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic [9:0] vert_a = '0, vert_b = '0, vert_c = '0, vert_d = '0;
  logic batch_end = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [42:0] normal_x, normal_y, normal_z;
  logic signed [19:0] centre_x, centre_y, centre_z;
  logic faces_out, found, batch_end_out;

  localparam logic [1:0] REG_TETRA_COUNT = 2'd0;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  face_scoreboard sb = new();
  bit quiet = 0;
  bit hold_req = 0;
  int cycles = 0;
  logic [9:0] pool[$];
  logic [9:0] tet_slots[$];

  oriented_triangle_normal_unit u_top (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("oriented_triangle_normal_unit test failed");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && out_ready)
      sb.check_result('{normal_x, normal_y, normal_z, centre_x, centre_y, centre_z,
                        faces_out, found, batch_end_out});

  // result side stalls, with one long hold-off to fill the block
  initial begin
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_ready <= 0;
        repeat (3000) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ready <= 1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  task automatic apb_write(logic [1:0] addr, logic [31:0] data);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (addr == REG_TETRA_COUNT) sb.tet_count = data[10:0];
  endtask

  task automatic send(load_item_t it);
    func <= it.func;
    slot <= it.slot;
    coord_x <= it.cx;
    coord_y <= it.cy;
    coord_z <= it.cz;
    vert_a <= it.va;
    vert_b <= it.vb;
    vert_c <= it.vc;
    vert_d <= it.vd;
    batch_end <= it.be;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    if (it.func == FUNC_POINT && !sb.pt_ok[it.slot]) pool.push_back(it.slot);
    sb.note_transfer(it);
    if (it.func == FUNC_POINT) sb.pt_ok[it.slot] = 1;
    if (it.func == FUNC_TETRA) tet_slots.push_back(it.slot);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.face_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic load_item_t noise();
    load_item_t it;
    it.func = 2'($urandom_range(0, 3));
    it.slot = 10'($urandom);
    it.cx = 20'($urandom);
    it.cy = 20'($urandom);
    it.cz = 20'($urandom);
    it.va = 10'($urandom);
    it.vb = 10'($urandom);
    it.vc = 10'($urandom);
    it.vd = 10'($urandom);
    it.be = 1'($urandom);
    return it;
  endfunction

  function automatic logic [9:0] pick_pt();
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  function automatic load_item_t query(logic [9:0] a, logic [9:0] b, logic [9:0] c);
    load_item_t it = noise();
    it.func = FUNC_QUERY;
    it.va = a;
    it.vb = b;
    it.vc = c;
    return it;
  endfunction

  function automatic load_item_t pattern_query(int s, int skip);
    logic [9:0] v[$];
    for (int k = 0; k < 4; k++) if (k != skip) v.push_back(sb.tets[s][k]);
    return query(v[0], v[1], v[2]);
  endfunction

  function automatic load_item_t rand_item();
    load_item_t it = noise();
    int r = $urandom_range(0, 99);
    int s;
    if (r < 18) begin
      it.func = FUNC_POINT;
      if ($urandom_range(0, 5) == 0) it.cx = $urandom_range(0, 1) ? 20'h80000 : 20'h7ffff;
    end else if (r < 36) begin
      it.func = FUNC_TETRA;
      if ($urandom_range(0, 1)) it.slot = 10'($urandom_range(0, 40));
      it.va = pick_pt();
      it.vb = pick_pt();
      it.vc = pick_pt();
      it.vd = pick_pt();
    end else if (r < 40) begin
      it.func = FUNC_NONE;
    end else begin
      for (int t = 0; t < 8; t++) begin
        if ($urandom_range(0, 9) < 7) begin
          s = tet_slots[$urandom_range(0, tet_slots.size() - 1)];
          it = pattern_query(s, $urandom_range(0, 3));
        end else begin
          it = query(pick_pt(), pick_pt(), pick_pt());
        end
        if (sb.query_ok(it.va, it.vb, it.vc)) return it;
      end
      it = pattern_query(0, 3);
    end
    return it;
  endfunction

  initial begin
    load_item_t it;
    int counts[7] = '{5, 2047, 17, 1024, 0, 3, 40};
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    apb_write(REG_TETRA_COUNT, 0);
    // points with extreme and ordinary coordinates
    for (int i = 0; i < 8; i++) begin
      it = noise();
      it.func = FUNC_POINT;
      it.slot = (i == 7) ? 10'd1023 : 10'(i);
      if (i == 0) begin
        it.cx = 20'h80000; it.cy = 20'h7ffff; it.cz = 20'h80000;
      end
      if (i == 1) begin
        it.cx = 20'h7ffff; it.cy = 20'h80000; it.cz = 20'h7ffff;
      end
      send(it);
    end
    it = noise();
    it.func = FUNC_TETRA;
    it.slot = 0;
    {it.va, it.vb, it.vc, it.vd} = {10'd0, 10'd1, 10'd2, 10'd1023};
    send(it);
    it.slot = 1;
    {it.va, it.vb, it.vc, it.vd} = {10'd3, 10'd4, 10'd5, 10'd6};
    send(it);
    it = noise();
    it.func = FUNC_NONE;
    send(it);
    send(query(10'd0, 10'd1, 10'd2));
    drain();
    apb_write(REG_TETRA_COUNT, 2);
    for (int p = 0; p < 4; p++) send(pattern_query(0, p));
    for (int p = 0; p < 4; p++) send(pattern_query(1, p));
    send(query(10'd2, 10'd1, 10'd0));
    send(query(10'd4, 10'd4, 10'd4));
    drain();
    foreach (counts[i]) begin
      apb_write(REG_TETRA_COUNT, (i == 6) ? $urandom_range(1, 60) : counts[i]);
      if (i == 0) hold_req = 1;
      if (i == 6) quiet = 1;
      for (int n = 0; n < 78; n++) send(rand_item());
      drain();
    end
    $display("%0d queries checked, %0d found a tetrahedron, %0d normals flipped",
             sb.n_query, sb.n_found, sb.n_flip);
    if (sb.errors == 0 && sb.face_q.size() == 0) begin
      $display("oriented_triangle_normal_unit test passed");
    end else begin
      $display("oriented_triangle_normal_unit test failed");
    end
    $finish;
  end
endmodule

[sim.f]
src/otn_pkg.sv
src/otn_ctrl.sv
src/otn_datapath.sv
src/oriented_triangle_normal_unit.sv
src/otn_checker.sv
sim/tb.sv
